@@ sv/lsis_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsis_pkg
// Shared types and constants for the linear systolic insertion sorter.
// ----------------------------------------------------------------------------
package lsis_pkg;

   localparam int VALUE_W       = 32;
   localparam int CELLS_DEFAULT = 8;

   localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   // value moving from one cell to the next
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } token_type;

   // row-wide control from the sequencer
   typedef struct packed {
      logic shift;   // move held values one cell toward cell 0
      logic clear;   // return every cell to INT_MAX
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ sv/lsis_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsis_cell
// One compare-swap cell: keeps the smaller value, hands the larger onward.
// ----------------------------------------------------------------------------
module lsis_cell (
   input  wire                               clock,
   input  wire                               reset,
   input  wire lsis_pkg::cell_ctrl_type      ctrl,
   input  wire lsis_pkg::token_type          token_i,
   input  wire logic signed [lsis_pkg::VALUE_W-1:0] right_value,
   output lsis_pkg::token_type               token_o,
   output logic signed [lsis_pkg::VALUE_W-1:0]      held_value
);
   import lsis_pkg::*;

   logic signed [VALUE_W-1:0] held_ff, held_in;
   token_type                 pass_ff, pass_in;

   always_comb begin
      held_in       = held_ff;
      pass_in.valid = 1'b0;
      pass_in.value = pass_ff.value;
      if (ctrl.clear) begin
         held_in = INT_MAX;
      end else if (ctrl.shift) begin
         held_in = right_value;
      end else if (token_i.valid) begin
         pass_in.valid = 1'b1;
         if (token_i.value < held_ff) begin
            held_in       = token_i.value;
            pass_in.value = held_ff;
         end else begin
            pass_in.value = token_i.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= INT_MAX;
         pass_ff.valid <= 1'b0;
      end else begin
         held_ff       <= held_in;
         pass_ff.valid <= pass_in.valid;
      end
      pass_ff.value <= pass_in.value;
   end

   assign token_o    = pass_ff;
   assign held_value = held_ff;

endmodule
`default_nettype wire

@@ sv/linear_systolic_insertion_sorter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// linear_systolic_insertion_sorter_unit
// Row of compare-swap cells that sorts a set of signed words, ascending.
// ----------------------------------------------------------------------------
// Loading: one word per cycle while req_tready is high (LOAD state); each
// word walks the row one cell per cycle. After the word marked tlast, the
// row settles in the FLUSH state, then the sorted words leave from cell 0
// at one per cycle while rsp_tready is high.
// Reset (synchronous) sets every cell to INT_MAX and clears count and flags.
// ----------------------------------------------------------------------------
module linear_systolic_insertion_sorter_unit #(
   parameter int CELLS = lsis_pkg::CELLS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [lsis_pkg::VALUE_W-1:0]       req_tdata,   // [31:0] value
   input  wire                               req_tlast,   // end_of_set
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [lsis_pkg::VALUE_W-1:0]      rsp_tdata,   // [31:0] sorted_value
   output logic                              rsp_tuser,   // [0] overflowed
   output logic                              rsp_tlast    // final_result
);
   import lsis_pkg::*;

   localparam int CW = $clog2(CELLS + 1);

   typedef enum logic [1:0] {LOAD, FLUSH, DRAIN} state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        remain_ff, remain_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 accept;
   logic                 take_out;
   cell_ctrl_type        ctrl;

   token_type                 tok   [CELLS+1];
   logic signed [VALUE_W-1:0] held  [CELLS];
   logic signed [VALUE_W-1:0] right [CELLS];

   assign req_tready = (state_ff == LOAD);
   assign accept     = req_tvalid && req_tready;
   assign take_out   = (state_ff == DRAIN) && (!rsp_valid_ff || rsp_tready);

   assign tok[0].valid = accept;
   assign tok[0].value = req_tdata;

   genvar g;
   generate
      for (g = 0; g < CELLS; g++) begin : g_cell
         if (g == CELLS - 1) begin : g_end
            assign right[g] = INT_MAX;
         end else begin : g_mid
            assign right[g] = held[g+1];
         end
         lsis_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .token_i     (tok[g]),
            .right_value (right[g]),
            .token_o     (tok[g+1]),
            .held_value  (held[g])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl.shift   = 1'b0;
      ctrl.clear   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         LOAD: begin
            if (accept) begin
               if (count_ff == CW'(CELLS)) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (req_tlast) begin
                  state_in  = FLUSH;
                  remain_in = CW'(CELLS - 1);
               end
            end
         end
         FLUSH: begin
            if (remain_ff == '0) begin
               state_in  = DRAIN;
               remain_in = count_ff;
            end else begin
               remain_in = remain_ff - 1'b1;
            end
         end
         DRAIN: begin
            if (take_out) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = held[0];
               rsp_user_in  = ovf_ff;
               rsp_last_in  = (remain_ff == CW'(1));
               remain_in    = remain_ff - 1'b1;
               ctrl.shift   = 1'b1;
               if (remain_ff == CW'(1)) begin
                  ctrl.clear = 1'b1;
                  state_in   = LOAD;
                  count_in   = '0;
                  ovf_in     = 1'b0;
               end
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         count_ff     <= '0;
         remain_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
